// ===== hdl/nvlp_pkg.sv =====
// Package for the name/value line parser: widths, constants, job record.
// No dependencies.
`default_nettype none
package nvlp_pkg;
  localparam int LineMax   = 128;
  localparam int NameLimit = 64;
  localparam int LenW      = $clog2(LineMax);
  localparam int NameAw    = $clog2(NameLimit);
  localparam int NameLenW  = $clog2(NameLimit + 1);

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoComma = 2'd1;
  localparam logic [1:0] StBadName = 2'd2;

  localparam logic [2:0] PhWs     = 3'd0;
  localparam logic [2:0] PhSign   = 3'd1;
  localparam logic [2:0] PhZero   = 3'd2;
  localparam logic [2:0] PhPrefix = 3'd3;
  localparam logic [2:0] PhBoth   = 3'd4;
  localparam logic [2:0] PhHex    = 3'd5;
  localparam logic [2:0] PhDone   = 3'd6;

  localparam logic [32:0] MagCap = 33'h1_0000_0000 >> 1;

  typedef struct packed {
    logic [1:0]          status;
    logic [NameLenW-1:0] name_len;
    logic signed [31:0]  value;
  } job_t;
endpackage
`default_nettype wire

// ===== hdl/nvlp_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module nvlp_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hdl/nvlp_front.sv =====
// Front end: frames lines, writes name bytes, scans the number, posts jobs.
// Depends on nvlp_pkg.
`default_nettype none
module nvlp_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       stall_o,
  input  wire logic [7:0]            rx_byte_i,
  output logic                       job_valid_o,
  input  wire logic                  job_stall_i,
  output nvlp_pkg::job_t             job_o,
  output logic                       wr_en_o,
  output logic [nvlp_pkg::NameAw-1:0] wr_addr_o,
  output logic [7:0]                 wr_data_o
);
  import nvlp_pkg::*;

  logic [LenW-1:0]     len_q, len_d;
  logic [NameLenW-1:0] nlen_q, nlen_d;
  logic                comma_q, comma_d, ended_q, ended_d, hexm_q, hexm_d, neg_q, neg_d;
  logic [2:0]          ph_q, ph_d;
  logic [32:0]         dec_q, dec_d, hex_q, hex_d;
  logic                acc_dec, acc_hex;
  logic [3:0]          hv;
  logic                is_hex, is_dig;
  logic [36:0]         dprod, hprod;
  logic                accept, is_lf, fire, clr;
  logic                name_byte;
  logic [32:0]         mag;
  logic signed [31:0]  val;

  assign accept  = valid_i && !stall_o;
  // name bytes wait while the back end still owns the name store
  assign name_byte = !is_lf && rx_byte_i != 8'h0d && len_q != LenW'(LineMax - 1) &&
                     !ended_q && rx_byte_i != 8'h00 && !comma_q && rx_byte_i != 8'h2c &&
                     nlen_q < NameLenW'(NameLimit);
  assign stall_o = (job_valid_o && job_stall_i) ||
                   (name_byte && (job_valid_o || job_stall_i));
  assign is_lf   = rx_byte_i == 8'h0a;
  assign fire    = accept && is_lf && (len_q != '0);

  always_comb begin
    is_dig = rx_byte_i inside {[8'h30:8'h39]};
    is_hex = 1'b1;
    hv     = 4'd0;
    if (is_dig) hv = rx_byte_i[3:0];
    else if (rx_byte_i inside {[8'h61:8'h66], [8'h41:8'h46]}) hv = rx_byte_i[3:0] + 4'd9;
    else is_hex = 1'b0;
  end

  assign dprod = {4'd0, dec_q} * 37'd10 + {33'd0, hv};
  assign hprod = {hex_q, 4'd0} + {33'd0, hv};

  always_comb begin
    mag = hexm_q ? hex_q : dec_q;
    if (mag > MagCap) mag = MagCap;
    if (neg_q) val = 32'(33'd0 - mag);
    else if (mag > {1'b0, 32'h7fff_ffff}) val = 32'h7fff_ffff;
    else val = mag[31:0];
  end

  always_comb begin
    len_d = len_q; nlen_d = nlen_q; comma_d = comma_q; ended_d = ended_q;
    hexm_d = hexm_q; neg_d = neg_q; ph_d = ph_q; dec_d = dec_q; hex_d = hex_q;
    acc_dec = 1'b0; acc_hex = 1'b0; clr = 1'b0;
    wr_en_o = 1'b0;
    if (accept) begin
      if (is_lf) begin
        if (len_q != '0) clr = 1'b1;
      end else if (rx_byte_i == 8'h0d) begin
      end else if (len_q == LenW'(LineMax - 1)) begin
        clr = 1'b1;
      end else begin
        len_d = len_q + 1'b1;
        if (ended_q) begin
        end else if (rx_byte_i == 8'h00) begin
          ended_d = 1'b1;
        end else if (!comma_q) begin
          if (rx_byte_i == 8'h2c) comma_d = 1'b1;
          else if (nlen_q < NameLenW'(NameLimit)) begin
            wr_en_o = 1'b1;
            nlen_d  = nlen_q + 1'b1;
          end
        end else begin
          if (rx_byte_i == 8'h78 || rx_byte_i == 8'h58) hexm_d = 1'b1;
          case (ph_q)
            PhWs, PhSign: begin
              if (ph_q == PhWs && (rx_byte_i == 8'h20 ||
                  rx_byte_i inside {[8'h09:8'h0d]})) begin
              end else if (ph_q == PhWs && (rx_byte_i == 8'h2b || rx_byte_i == 8'h2d)) begin
                neg_d = rx_byte_i == 8'h2d;
                ph_d  = PhSign;
              end else if (rx_byte_i == 8'h30) ph_d = PhZero;
              else if (is_dig) begin
                acc_dec = 1'b1; acc_hex = 1'b1; ph_d = PhBoth;
              end else if (is_hex) begin
                acc_hex = 1'b1; ph_d = PhHex;
              end else ph_d = PhDone;
            end
            PhZero, PhBoth: begin
              if (rx_byte_i == 8'h78 || rx_byte_i == 8'h58)
                ph_d = (ph_q == PhZero) ? PhPrefix : PhDone;
              else if (is_dig) begin
                acc_dec = 1'b1; acc_hex = 1'b1; ph_d = PhBoth;
              end else if (is_hex) begin
                acc_hex = 1'b1; ph_d = PhHex;
              end else ph_d = PhDone;
            end
            PhPrefix, PhHex: begin
              if (is_hex) begin
                acc_hex = 1'b1; ph_d = PhHex;
              end else ph_d = PhDone;
            end
            default: ;
          endcase
          if (acc_dec) dec_d = (dprod > 37'(MagCap)) ? MagCap : dprod[32:0];
          if (acc_hex) hex_d = (hprod > 37'(MagCap)) ? MagCap : hprod[32:0];
        end
      end
    end
    if (clr) begin
      len_d = '0; nlen_d = '0; comma_d = 1'b0; ended_d = 1'b0; hexm_d = 1'b0;
      neg_d = 1'b0; ph_d = PhWs; dec_d = '0; hex_d = '0;
    end
  end

  assign wr_addr_o = nlen_q[NameAw-1:0];
  assign wr_data_o = rx_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0; nlen_q <= '0; comma_q <= 1'b0; ended_q <= 1'b0; hexm_q <= 1'b0;
      neg_q <= 1'b0; ph_q <= PhWs; dec_q <= '0; hex_q <= '0;
      job_valid_o <= 1'b0;
    end else begin
      len_q <= len_d; nlen_q <= nlen_d; comma_q <= comma_d; ended_q <= ended_d;
      hexm_q <= hexm_d; neg_q <= neg_d; ph_q <= ph_d; dec_q <= dec_d; hex_q <= hex_d;
      if (fire) job_valid_o <= 1'b1;
      else if (!job_stall_i) job_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      job_o.name_len <= nlen_q;
      job_o.value    <= val;
      if (!comma_q) job_o.status <= StNoComma;
      else if (nlen_q == '0 || nlen_q >= NameLenW'(NameLimit)) job_o.status <= StBadName;
      else job_o.status <= StOk;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> !job_valid_o && !job_stall_i)
    else $error("name store written while in use");
  assert property (@(posedge clk_i) disable iff (!rst_ni) nlen_q <= NameLenW'(NameLimit))
    else $error("name length overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni) fire |=> job_valid_o)
    else $error("job lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni) dec_q <= MagCap && hex_q <= MagCap)
    else $error("total beyond cap");
endmodule
`default_nettype wire

// ===== hdl/nvlp_back.sv =====
// Back end: takes a job and reads the name run out of the store, one beat per byte.
// Depends on nvlp_pkg.
`default_nettype none
module nvlp_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   job_valid_i,
  output logic                        job_stall_o,
  input  nvlp_pkg::job_t              job_i,
  output logic [nvlp_pkg::NameAw-1:0] rd_addr_o,
  input  wire logic [7:0]             rd_data_i,
  output logic                        valid_o,
  input  wire logic                   stall_i,
  output logic [1:0]                  status_o,
  output logic [7:0]                  name_char_o,
  output logic signed [31:0]          value_o,
  output logic                        last_o
);
  import nvlp_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SRead = 2'd1;
  localparam logic [1:0] SOut  = 2'd2;

  logic [1:0]          st_q;
  job_t                job_q;
  logic [NameLenW-1:0] idx_q;
  logic [NameAw-1:0]   idx_lo;
  logic                fin;

  assign job_stall_o = st_q != SIdle;
  assign idx_lo      = idx_q[NameAw-1:0];
  // address of the byte shown next, so the registered read is ready in SRead
  assign rd_addr_o   = (st_q == SIdle) ? '0 :
                       (st_q == SOut && !stall_i) ? idx_lo + 1'b1 : idx_lo;
  assign fin         = idx_q + 1'b1 == job_q.name_len;
  assign valid_o     = st_q == SOut;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      idx_q <= '0;
    end else begin
      case (st_q)
        SIdle: if (job_valid_i) begin
          idx_q <= '0;
          st_q  <= (job_i.status == StOk) ? SRead : SOut;
        end
        SRead: st_q <= SOut;
        SOut: if (!stall_i) begin
          if (job_q.status != StOk || fin) st_q <= SIdle;
          else begin
            idx_q <= idx_q + 1'b1;
            st_q  <= SRead;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && job_valid_i) begin
      job_q <= job_i;
      if (job_i.status != StOk) begin
        status_o <= job_i.status; name_char_o <= 8'd0; value_o <= '0; last_o <= 1'b1;
      end
    end
    if (st_q == SRead) begin
      status_o    <= StOk;
      name_char_o <= rd_data_i;
      value_o     <= fin ? job_q.value : 32'sd0;
      last_o      <= fin;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !stall_i && last_o |=> st_q == SIdle) else $error("run not ended");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != StOk |-> last_o) else $error("error beat not last");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == SRead |=> st_q == SOut) else $error("read not shown");
endmodule
`default_nettype wire

// ===== hdl/name_value_line_parser.sv =====
// Top level of the NAME,VALUE line parser.
// Depends on nvlp_pkg, nvlp_front, nvlp_back, nvlp_ram.
//
// Input channel: rx_byte_i with valid_i/stall_o, one byte per beat.
// Output channel: status_o, name_char_o, value_o, last_o with valid_o/stall_i.
// An LF closing a non-empty line posts a job to a one-entry queue; the back
// end then emits one beat per name byte, each read from the name store and
// then loaded into the output register, value and last on the final beat.
// A bad line gives one error beat with last set. The first beat passes the
// queue register, SRead and the output register; an error beat skips SRead.
// The front keeps taking bytes while the back emits, but a byte that would
// be written to the name store waits while a job is queued or being emitted,
// and any byte waits while the queue holds a job the busy back has not taken.
// Reset clears all line state; the name store needs no clearing, every byte
// read was written earlier in the same line.
// While stall_i is high the output beat holds.
`default_nettype none
module name_value_line_parser (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  output logic              stall_o,
  input  wire logic [7:0]   rx_byte_i,
  output logic              valid_o,
  input  wire logic         stall_i,
  output logic [1:0]        status_o,
  output logic [7:0]        name_char_o,
  output logic signed [31:0] value_o,
  output logic              last_o
);
  import nvlp_pkg::*;

  logic              job_valid, job_stall, wr_en;
  job_t              job;
  logic [NameAw-1:0] wr_addr, rd_addr;
  logic [7:0]        wr_data, rd_data;

  nvlp_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .rx_byte_i,
    .job_valid_o(job_valid), .job_stall_i(job_stall), .job_o(job),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data)
  );

  nvlp_ram #(.Width(8), .Depth(NameLimit)) u_ram (
    .clk_i, .we_i(wr_en), .waddr_i(wr_addr), .wdata_i(wr_data),
    .raddr_i(rd_addr), .rdata_o(rd_data)
  );

  nvlp_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_stall_o(job_stall), .job_i(job),
    .rd_addr_o(rd_addr), .rd_data_i(rd_data),
    .valid_o, .stall_i, .status_o, .name_char_o, .value_o, .last_o
  );
endmodule
`default_nettype wire
